// ----- sv/linear_probe_hash_table_macros.svh -----
// assertion macros shared by the hash table rtl
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define LPHT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpht assertion failed");

// next-cycle implication, disabled while reset is asserted
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpht assertion failed");

`endif

// ----- sv/lpht_pkg.sv -----
// types and constants of the linear probing hash table
package lpht_pkg;

  localparam int KEY_W     = 64;
  localparam int VAL_W     = 64;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 3;
  localparam int ENTRIES_W = 10;
  localparam int IN_DATA_W = 128;
  localparam int OUT_DATA_W = 80;
  localparam int OUT_PAD_W = OUT_DATA_W - VAL_W - ENTRIES_W;

  // operation codes
  localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_MISS    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HIT     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NEW     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd4;

  // one table slot as stored in the slot memory
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  // one result item handed to the output stage
  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [VAL_W-1:0]     found_value;
    logic [ENTRIES_W-1:0] entries_held;
  } res_t;

endpackage

// ----- sv/lpht_out_buf.sv -----
// output register stage of the hash table result stream
module lpht_out_buf (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  lpht_pkg::res_t                res,
  output logic                          can_load,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // fields from bit 0: found_value[63:0], entries_held[73:64], zero pad
  output logic [lpht_pkg::OUT_DATA_W-1:0] out_tdata,
  // fields from bit 0: status[2:0]
  output logic [lpht_pkg::STATUS_W-1:0] out_tuser
);
  import lpht_pkg::*;

  logic valid_r;
  res_t res_r;

  // free when empty or when the held item leaves this cycle
  assign can_load = !valid_r || out_tready;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, res_r.entries_held, res_r.found_value};
  assign out_tuser  = res_r.status;

endmodule

// ----- sv/linear_probe_hash_table.sv -----
// top level of the linear probing hash table with its slot memory and probe sequencer
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready   | tuser opcode, tdata key and value
//  out_    | out | out_tvalid/out_tready | tuser status, tdata found_value, entries_held
//
// find and insert probe slot after slot from the home slot: one memory read per cycle
// opcode 3, a zero key, find on an empty table and insert at half load skip the probe walk
// clear sweeps the slot memory one slot a cycle; after reset the same sweep runs with
// in_tready low; the user must keep SLOTS a power of two; the block does not enforce it
// a held result stalls only the final handoff of the next item
`include "linear_probe_hash_table_macros.svh"

module linear_probe_hash_table #(
  parameter int SLOTS = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // fields from bit 0: key[63:0], value[127:64]
  input  logic [lpht_pkg::IN_DATA_W-1:0]  in_tdata,
  // fields from bit 0: opcode[1:0]
  input  logic [lpht_pkg::OP_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // fields from bit 0: found_value[63:0], entries_held[73:64], zero pad
  output logic [lpht_pkg::OUT_DATA_W-1:0] out_tdata,
  // fields from bit 0: status[2:0]
  output logic [lpht_pkg::STATUS_W-1:0]   out_tuser
);
  import lpht_pkg::*;

  localparam int IW   = $clog2(SLOTS);
  localparam int HALF = SLOTS / 2;
  localparam int CW   = $clog2(HALF + 1);

  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);
  localparam logic [CW-1:0] HALF_CNT  = CW'(HALF);

  // sequencer states
  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_CHK  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [OP_W-1:0]  op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [IW-1:0]    slot_r, slot_nxt;
  logic [IW-1:0]    probe_r, probe_nxt;
  logic [IW-1:0]    clr_r, clr_nxt;
  logic             clr_res_r, clr_res_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  res_t             res_r, res_nxt;

  // slot memory and its registered read port
  entry_t           mem [SLOTS];
  entry_t           rd_r;
  logic             mem_we;
  logic [IW-1:0]    mem_wa;
  entry_t           mem_wd;
  logic [IW-1:0]    rd_addr;

  logic [OP_W-1:0]  in_op;
  logic [KEY_W-1:0] in_key;
  logic [VAL_W-1:0] in_val;
  logic [31:0]      fold;
  logic [IW-1:0]    home;
  logic             in_fire;
  logic             rd_empty;
  logic             rd_match;
  logic             buf_load;
  logic             buf_can_load;

  assign in_op  = in_tuser;
  assign in_key = in_tdata[KEY_W-1:0];
  assign in_val = in_tdata[KEY_W +: VAL_W];

  // home slot: low bits of upper half xor lower half
  assign fold = in_key[31:0] ^ in_key[63:32];
  assign home = fold[IW-1:0];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign rd_empty = (rd_r.key == '0);
  assign rd_match = (rd_r.key == key_r);

  // sequencer next state
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    key_nxt     = key_r;
    val_nxt     = val_r;
    slot_nxt    = slot_r;
    probe_nxt   = probe_r;
    clr_nxt     = clr_r;
    clr_res_nxt = clr_res_r;
    count_nxt   = count_r;
    res_nxt     = res_r;
    mem_we      = 1'b0;
    mem_wa      = slot_r;
    mem_wd      = '{key: key_r, value: val_r};
    rd_addr     = slot_r + 1'b1;
    buf_load    = 1'b0;

    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_SLOT) begin
          if (clr_res_r) begin
            res_nxt   = '{status: ST_MISS, found_value: '0, entries_held: '0};
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_IDLE: begin
        rd_addr = home;
        if (in_fire) begin
          op_nxt    = in_op;
          key_nxt   = in_key;
          val_nxt   = in_val;
          slot_nxt  = home;
          probe_nxt = '0;
          res_nxt   = '{status: ST_IGNORED, found_value: '0,
                        entries_held: ENTRIES_W'(count_r)};
          case (in_op)
            OP_FIND: begin
              if (in_key == '0 || count_r == '0) begin
                res_nxt.status = ST_MISS;
                state_nxt      = S_FIN;
              end else begin
                state_nxt = S_CHK;
              end
            end
            OP_INSERT: begin
              if (in_key == '0 || count_r >= HALF_CNT) begin
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_CHK;
              end
            end
            OP_CLEAR: begin
              clr_nxt     = '0;
              clr_res_nxt = 1'b1;
              count_nxt   = '0;
              state_nxt   = S_CLR;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      S_CHK: begin
        // rd_r holds the slot at slot_r; the next slot is being read meanwhile
        if (rd_empty) begin
          state_nxt = S_FIN;
          if (op_r == OP_INSERT) begin
            mem_we                = 1'b1;
            count_nxt             = count_r + 1'b1;
            res_nxt.status        = ST_NEW;
            res_nxt.entries_held  = ENTRIES_W'(count_r + 1'b1);
          end else begin
            res_nxt.status = ST_MISS;
          end
        end else if (rd_match) begin
          state_nxt = S_FIN;
          if (op_r == OP_INSERT) begin
            mem_we         = 1'b1;
            res_nxt.status = ST_UPDATED;
          end else begin
            res_nxt.status      = ST_HIT;
            res_nxt.found_value = rd_r.value;
          end
        end else if (probe_r == LAST_SLOT) begin
          // walk covered every slot without an end
          state_nxt      = S_FIN;
          res_nxt.status = (op_r == OP_INSERT) ? ST_IGNORED : ST_MISS;
        end else begin
          slot_nxt  = slot_r + 1'b1;
          probe_nxt = probe_r + 1'b1;
        end
      end

      S_FIN: begin
        if (buf_can_load) begin
          buf_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_r     <= '0;
      clr_res_r <= 1'b0;
      count_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      clr_res_r <= clr_res_nxt;
      count_r   <= count_nxt;
    end
  end

  // item payload and probe position
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    key_r   <= key_nxt;
    val_r   <= val_nxt;
    slot_r  <= slot_nxt;
    probe_r <= probe_nxt;
    res_r   <= res_nxt;
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_r <= mem[rd_addr];
  end

  // result register toward the output stream
  lpht_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (buf_load),
    .res        (res_r),
    .can_load   (buf_can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // checks
  `LPHT_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= HALF_CNT)
  `LPHT_ASSERT_NOW(a_probe_write_insert, clk, rst_n, mem_we && state_r == S_CHK, op_r == OP_INSERT)
  `LPHT_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_fire, state_r != S_IDLE)
  `LPHT_ASSERT_NEXT(a_fin_handoff, clk, rst_n, state_r == S_FIN && buf_can_load, out_tvalid && state_r == S_IDLE)

endmodule
